### src/ssb_pkg.sv
`timescale 1ns / 1ps

package ssb_pkg;

   // Default geometry
   localparam int SCREEN_W_DEF   = 128;
   localparam int SCREEN_H_DEF   = 128;
   localparam int BG_RES_DEF     = 128;
   localparam int SPRITE_RES_DEF = 32;

   // Field and store widths
   localparam int STORE_AW  = 14;
   localparam int COLOR_W   = 16;
   localparam int CENTER_W  = 10;
   localparam int CSR_IDX_W = 1;

   // Shared divider: 16-bit dividend, 8-bit divisor, one quotient bit per cycle
   localparam int DIV_NUM_W = 16;
   localparam int DIV_DEN_W = 8;

   localparam logic [DIV_DEN_W-1:0] RATIO_DEN    = 8'd255;
   localparam logic [COLOR_W-1:0]   WHITE        = 16'hffff;
   localparam logic [CENTER_W-1:0]  CENTER_RESET = 10'd64;

   // Item modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 1'd1;

   typedef struct packed {
      logic [1:0]          mode;
      logic [13:0]         load_address;
      logic [15:0]         load_color;
      logic                is_background;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic [7:0]          width_ratio;
      logic [7:0]          height_ratio;
   } req_type;

   typedef struct packed {
      logic        write_valid;
      logic [13:0] write_address;
      logic [15:0] write_color;
      logic        done_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_COL,
      ST_DIV_ROW,
      ST_INDEX,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

### src/ssb_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ssb_divider
   import ssb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   part;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   always_comb begin
      part    = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = part - {1'b0, den_ff};
      fits    = part >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : part[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### src/ssb_store.sv
`timescale 1ns / 1ps

// Source image store, one write and one registered read per cycle.
module ssb_store
   import ssb_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [STORE_AW-1:0] wr_addr,
   input  logic [COLOR_W-1:0]  wr_data,
   input  logic                rd_en,
   input  logic [STORE_AW-1:0] rd_addr,
   output logic [COLOR_W-1:0]  rd_data
);

   logic [COLOR_W-1:0] mem [2**STORE_AW];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/scaled_sprite_blitter_core.sv
`timescale 1ns / 1ps
// Sequence: load, no-op, layer start and empty-layer step go from acceptance straight
// to the output state; a pixel step makes two passes through the shared bit-serial
// divider (source column, then row), then goes through index, read and output states.
// One item at a time, and the output state waits on result stalls; req_stall is high
// until the result is queued.
// Reset (synchronous, active high) clears layer, cursor and centers (64), not the store.
module scaled_sprite_blitter_core
   import ssb_pkg::*;
#(
   parameter int SCREEN_W   = SCREEN_W_DEF,
   parameter int SCREEN_H   = SCREEN_H_DEF,
   parameter int BG_RES     = BG_RES_DEF,
   parameter int SPRITE_RES = SPRITE_RES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CENTER_W-1:0]  csr_wdata
);

   localparam logic [7:0]          SCR_W8     = 8'(SCREEN_W);
   localparam logic [7:0]          SCR_H8     = 8'(SCREEN_H);
   localparam logic [7:0]          BG_RES8    = 8'(BG_RES);
   localparam logic [7:0]          SPR_RES8   = 8'(SPRITE_RES);
   localparam logic [STORE_AW-1:0] SCR_W14    = STORE_AW'(SCREEN_W);
   localparam logic [17:0]         SCR_W18    = 18'(SCREEN_W);
   localparam logic [17:0]         SCR_H18    = 18'(SCREEN_H);

   // Sequencer state
   state_type state_ff, state_in;

   // Configuration
   logic [CENTER_W-1:0] center_x_ff, center_x_in;
   logic [CENTER_W-1:0] center_y_ff, center_y_in;

   // Layer description and cursor
   logic [16:0] base_x_ff, base_x_in;
   logic [16:0] base_y_ff, base_y_in;
   logic [7:0]  lw_ff, lw_in;
   logic [7:0]  lh_ff, lh_in;
   logic        layer_bg_ff, layer_bg_in;
   logic [7:0]  cur_x_ff, cur_x_in;
   logic [7:0]  cur_y_ff, cur_y_in;

   // Per-item working registers
   logic [17:0]         dx_ff, dx_in;
   logic [17:0]         dy_ff, dy_in;
   logic                inside_ff, inside_in;
   logic                emit_pix_ff, emit_pix_in;
   logic                done_ff, done_in;
   logic [7:0]          col_ff, col_in;
   logic [7:0]          row_ff, row_in;
   logic [STORE_AW-1:0] idx_ff, idx_in;
   logic [STORE_AW-1:0] dst_ff, dst_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Shared divider and store hookup
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                 store_wr_en;
   logic                 store_rd_en;
   logic [COLOR_W-1:0]   store_rd_data;

   logic [7:0]  res_sel;
   logic [15:0] idx_prod;
   logic [8:0]  next_x;
   logic [8:0]  next_y;
   logic [COLOR_W-1:0] pix_color;
   logic        pix_write;
   logic        out_free;
   logic [15:0] w_prod;
   logic [15:0] h_prod;
   logic [15:0] w_sum;
   logic [15:0] h_sum;

   ssb_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   ssb_store u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (req_data.load_address),
      .wr_data (req_data.load_color),
      .rd_en   (store_rd_en),
      .rd_addr (idx_ff),
      .rd_data (store_rd_data)
   );

   // Accept only between items; a waiting result does not block acceptance.
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Source resolution of the current layer.
   assign res_sel  = layer_bg_ff ? BG_RES8 : SPR_RES8;
   assign idx_prod = 16'(row_ff) * 16'(res_sel);
   assign next_x   = {1'b0, cur_x_ff} + 9'd1;
   assign next_y   = {1'b0, cur_y_ff} + 9'd1;

   // Sprite size = ratio * screen / 255. For p below 65280,
   // floor(p / 255) = (p + (p >> 8) + 1) >> 8.
   assign w_prod = 16'(req_data.width_ratio) * 16'(SCR_W8);
   assign h_prod = 16'(req_data.height_ratio) * 16'(SCR_H8);
   assign w_sum  = w_prod + {8'b0, w_prod[15:8]} + 16'd1;
   assign h_sum  = h_prod + {8'b0, h_prod[15:8]} + 16'd1;

   // Background shows transparent source pixels as white; sprites skip them.
   always_comb begin
      pix_color = store_rd_data;
      if (layer_bg_ff && (store_rd_data == '0)) begin
         pix_color = WHITE;
      end
      pix_write = emit_pix_ff && inside_ff && (pix_color != '0);
   end

   // Configuration writes
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_in = csr_wdata;
            CSR_CENTER_Y: center_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      lw_in        = lw_ff;
      lh_in        = lh_ff;
      layer_bg_in  = layer_bg_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      inside_in    = inside_ff;
      emit_pix_in  = emit_pix_ff;
      done_in      = done_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      store_wr_en  = 1'b0;
      store_rd_en  = 1'b0;

      // Drop the result once the consumer takes it.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               emit_pix_in = 1'b0;
               done_in     = 1'b0;
               state_in    = ST_EMIT;
               unique case (req_data.mode)
                  MODE_LOAD: begin
                     store_wr_en = 1'b1;
                  end
                  MODE_START: begin
                     cur_x_in = '0;
                     cur_y_in = '0;
                     if (req_data.is_background) begin
                        layer_bg_in = 1'b1;
                        base_x_in   = '0;
                        base_y_in   = '0;
                        lw_in       = SCR_W8;
                        lh_in       = SCR_H8;
                     end else begin
                        layer_bg_in = 1'b0;
                        base_x_in   = {req_data.pos_x[15], req_data.pos_x}
                                    + {7'b0, center_x_ff};
                        base_y_in   = {7'b0, center_y_ff}
                                    - {req_data.pos_y[15], req_data.pos_y};
                        lw_in       = w_sum[15:8];
                        lh_in       = h_sum[15:8];
                     end
                  end
                  MODE_STEP: begin
                     if ((lw_ff == '0) || (lh_ff == '0)) begin
                        done_in = 1'b1;
                     end else begin
                        emit_pix_in = 1'b1;
                        dx_in     = {10'b0, cur_x_ff} + {base_x_ff[16], base_x_ff};
                        dy_in     = {10'b0, cur_y_ff} + {base_y_ff[16], base_y_ff};
                        done_in   = (next_x == {1'b0, lw_ff}) && (next_y == {1'b0, lh_ff});
                        // Source column = cursor_x * res / width.
                        div_start = 1'b1;
                        div_num   = 16'(cur_x_ff) * 16'(res_sel);
                        div_den   = lw_ff;
                        state_in  = ST_DIV_COL;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_DIV_COL: begin
            // Clip test and framebuffer address while the divider runs.
            inside_in = !dx_ff[17] && (dx_ff < SCR_W18) && !dy_ff[17] && (dy_ff < SCR_H18);
            dst_in    = dy_ff[STORE_AW-1:0] * SCR_W14 + dx_ff[STORE_AW-1:0];
            if (div_done) begin
               col_in    = div_quo[7:0];
               // Source row = cursor_y * res / height.
               div_start = 1'b1;
               div_num   = 16'(cur_y_ff) * 16'(res_sel);
               div_den   = lh_ff;
               state_in  = ST_DIV_ROW;
            end
         end

         ST_DIV_ROW: begin
            if (div_done) begin
               row_in = div_quo[7:0];
               // Advance the cursor in row-major order, wrapping at the end.
               if (next_x >= {1'b0, lw_ff}) begin
                  cur_x_in = '0;
                  if (next_y >= {1'b0, lh_ff}) begin
                     cur_y_in = '0;
                  end else begin
                     cur_y_in = next_y[7:0];
                  end
               end else begin
                  cur_x_in = next_x[7:0];
               end
               state_in = ST_INDEX;
            end
         end

         ST_INDEX: begin
            idx_in   = idx_prod[STORE_AW-1:0] + {{(STORE_AW-8){1'b0}}, col_ff};
            state_in = ST_READ;
         end

         ST_READ: begin
            store_rd_en = 1'b1;
            state_in    = ST_EMIT;
         end

         ST_EMIT: begin
            // Hold the item here until the result register is free.
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.write_valid   = pix_write;
               rsp_data_in.write_address = pix_write ? dst_ff : '0;
               rsp_data_in.write_color   = pix_write ? pix_color : '0;
               rsp_data_in.done_res      = done_ff;
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         center_x_ff  <= CENTER_RESET;
         center_y_ff  <= CENTER_RESET;
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         lw_ff        <= '0;
         lh_ff        <= '0;
         layer_bg_ff  <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         base_x_ff    <= base_x_in;
         base_y_ff    <= base_y_in;
         lw_ff        <= lw_in;
         lh_ff        <= lh_in;
         layer_bg_ff  <= layer_bg_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      inside_ff   <= inside_in;
      emit_pix_ff <= emit_pix_in;
      done_ff     <= done_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      idx_ff      <= idx_in;
      dst_ff      <= dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
